// File: rtl/smm_pkg.sv
`default_nettype none

package smm_pkg;

    // matrix size and element width
    localparam int DIM           = 3;
    localparam int ELEMENT_WIDTH = 16;

    // fixed port widths
    localparam int IN_WIDTH  = 16;
    localparam int SUM_WIDTH = 33;

    // derived widths
    localparam int PROD_WIDTH = 2 * ELEMENT_WIDTH;
    localparam int IDX_W      = $clog2(DIM);

    typedef logic signed [ELEMENT_WIDTH-1:0] t_elem;
    typedef logic signed [SUM_WIDTH-1:0]     t_sum;
    typedef logic        [IDX_W-1:0]         t_idx;

    localparam t_idx IDX_MAX = t_idx'(DIM - 1);

    // partial sum travelling down the chain with its output position
    typedef struct packed {
        logic valid;
        t_idx row;
        t_idx col;
        t_sum sum;
    } t_flow;

    // element write into one cell's slice of a or b
    typedef struct packed {
        logic  we_a;
        logic  we_b;
        t_idx  idx;
        t_elem data;
    } t_load;

endpackage

`default_nettype wire

// File: rtl/square_matrix_multiply_core.sv
`default_nettype none

// Square matrix multiplier. Signed elements arrive one per request in
// row-major order: DIM*DIM elements of A, then DIM*DIM elements of B, each at
// one per cycle while o_stall is low. Accepting the last element of B starts
// the product: the DIM*DIM output positions enter a chain of DIM multiply-add
// cells at one per cycle unless the output stalls, each cell adding its
// a[row][k]*b[k][col] term over two register stages. Each output position
// passes the issue register, both stages of every cell and the output
// register, and products leave one per cycle unless the output stalls.
// Products are exact sums truncated to 33 bits; the final one carries is_last.
// Input is stalled from the last B element until the final product has left
// the cell chain.
module square_matrix_multiply_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [smm_pkg::IN_WIDTH-1:0]  i_element,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [smm_pkg::SUM_WIDTH-1:0] o_product_element,
    output logic                                o_is_last
);
    import smm_pkg::*;

    logic  r_phase_b;
    t_idx  r_ld_row;
    t_idx  r_ld_col;
    logic  r_busy;
    logic  r_iss_active;
    t_idx  r_iss_row;
    t_idx  r_iss_col;
    logic  r_out_valid;
    t_sum  r_out_sum;
    logic  r_out_last;

    logic  w_in_acc;
    logic  w_row_end;
    logic  w_ld_last;
    logic  w_last_b;
    logic  w_en;
    logic  w_out_last;
    t_elem w_elem;
    t_load w_load [DIM];
    t_flow w_flow [DIM+1];

    assign o_stall  = r_busy;
    assign w_in_acc = i_valid && !r_busy;
    assign w_elem   = t_elem'(i_element);

    assign w_row_end = (r_ld_col == IDX_MAX);
    assign w_ld_last = w_row_end && (r_ld_row == IDX_MAX);
    assign w_last_b  = w_in_acc && r_phase_b && w_ld_last;

    // whole chain advances unless a finished product is held
    assign w_en = !r_out_valid || !i_stall;

    // load position: a element (row,k) goes to cell k, b element (k,col) to cell k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_b <= 1'b0;
            r_ld_row  <= '0;
            r_ld_col  <= '0;
        end else if (w_in_acc) begin
            if (w_row_end) begin
                r_ld_col <= '0;
                if (w_ld_last) begin
                    r_ld_row  <= '0;
                    r_phase_b <= !r_phase_b;
                end else begin
                    r_ld_row <= r_ld_row + 1'b1;
                end
            end else begin
                r_ld_col <= r_ld_col + 1'b1;
            end
        end
    end

    // issue output positions in row-major order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_active <= 1'b0;
            r_iss_row    <= '0;
            r_iss_col    <= '0;
        end else if (w_last_b) begin
            r_iss_active <= 1'b1;
            r_iss_row    <= '0;
            r_iss_col    <= '0;
        end else if (w_en && r_iss_active) begin
            if (r_iss_col == IDX_MAX) begin
                r_iss_col <= '0;
                if (r_iss_row == IDX_MAX) begin
                    r_iss_row    <= '0;
                    r_iss_active <= 1'b0;
                end else begin
                    r_iss_row <= r_iss_row + 1'b1;
                end
            end else begin
                r_iss_col <= r_iss_col + 1'b1;
            end
        end
    end

    assign w_flow[0] = '{valid: r_iss_active, row: r_iss_row, col: r_iss_col, sum: '0};

    // chain of multiply-add cells, one per k
    for (genvar k = 0; k < DIM; k++) begin : g_cell
        assign w_load[k] = '{
            we_a: w_in_acc && !r_phase_b && (r_ld_col == t_idx'(k)),
            we_b: w_in_acc && r_phase_b && (r_ld_row == t_idx'(k)),
            idx:  r_phase_b ? r_ld_col : r_ld_row,
            data: w_elem
        };

        smm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_load  (w_load[k]),
            .i_flow  (w_flow[k]),
            .o_flow  (w_flow[k+1])
        );
    end

    assign w_out_last = (w_flow[DIM].row == IDX_MAX) && (w_flow[DIM].col == IDX_MAX);

    // busy from last b element until the final product leaves the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_last_b) begin
            r_busy <= 1'b1;
        end else if (w_en && w_flow[DIM].valid && w_out_last) begin
            r_busy <= 1'b0;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_flow[DIM].valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sum  <= w_flow[DIM].sum;
            r_out_last <= w_out_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_product_element = r_out_sum;
    assign o_is_last         = r_out_last;

    // issuing only happens while input is held off
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_active |-> r_busy)
        else $error("issue active while input open");

    // products in the chain only while busy
    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flow[DIM].valid |-> r_busy)
        else $error("product in chain while not busy");

    // once input reopens, a held product is the final one
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> r_out_last)
        else $error("non-final product held after busy cleared");

    // last b element starts issue at the first position
    a_issue_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_b |=> (r_iss_active && r_iss_row == '0 && r_iss_col == '0))
        else $error("issue did not start at first position");

endmodule

`default_nettype wire

// File: rtl/smm_cell.sv
`default_nettype none

module smm_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  smm_pkg::t_load i_load,
    input  smm_pkg::t_flow i_flow,
    output smm_pkg::t_flow o_flow
);
    import smm_pkg::*;

    // column k of a (indexed by row) and row k of b (indexed by col)
    t_elem r_a [DIM];
    t_elem r_b [DIM];

    logic                         r_v1;
    t_idx                         r_row1;
    t_idx                         r_col1;
    t_sum                         r_sum1;
    t_sum                         r_prod;
    logic                         r_v2;
    t_idx                         r_row2;
    t_idx                         r_col2;
    t_sum                         r_sum2;
    logic signed [PROD_WIDTH-1:0] w_prod;
    t_sum                         n_sum;

    // element stores
    always_ff @(posedge i_clk) begin
        if (i_load.we_a) begin
            r_a[i_load.idx] <= i_load.data;
        end
        if (i_load.we_b) begin
            r_b[i_load.idx] <= i_load.data;
        end
    end

    // a[row][k] * b[k][col]
    assign w_prod = r_a[i_flow.row] * r_b[i_flow.col];

    // add this cell's term to the incoming partial sum
    assign n_sum = r_sum1 + r_prod;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_flow.valid;
            r_v2 <= r_v1;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row1 <= i_flow.row;
            r_col1 <= i_flow.col;
            r_sum1 <= i_flow.sum;
            r_prod <= t_sum'(w_prod);
            r_row2 <= r_row1;
            r_col2 <= r_col1;
            r_sum2 <= n_sum;
        end
    end

    assign o_flow = '{valid: r_v2, row: r_row2, col: r_col2, sum: r_sum2};

endmodule

`default_nettype wire

// File: tb/sv/matrix_product_checker.sv
// watches both channels of the matrix multiplier, predicts every product
// element from the accepted requests and compares the results in order
module matrix_product_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_elem_valid,
    input  logic                                 i_elem_stall,
    input  logic signed [smm_pkg::IN_WIDTH-1:0]  i_element,
    input  logic                                 i_prod_valid,
    input  logic                                 i_prod_stall,
    input  logic signed [smm_pkg::SUM_WIDTH-1:0] i_product_element,
    input  logic                                 i_is_last,
    output int                                   o_mismatch_count,
    output int                                   o_outstanding
);
    import smm_pkg::*;

    localparam int CELLS       = DIM * DIM;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        t_sum value;
        logic last;
    } t_product;

    t_elem    matrix_a [CELLS];
    t_elem    matrix_b [CELLS];
    int       loaded_count;
    t_product product_queue [$];
    int       mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    // full product of the stored pair, exact in 64 bits, cut to the port width
    task automatic push_products();
        longint   acc;
        t_product p;
        for (int row = 0; row < DIM; row++) begin
            for (int col = 0; col < DIM; col++) begin
                acc = 0;
                for (int k = 0; k < DIM; k++)
                    acc += longint'(matrix_a[row * DIM + k]) * longint'(matrix_b[k * DIM + col]);
                p.value = t_sum'(acc);
                p.last  = (row == DIM - 1) && (col == DIM - 1);
                product_queue.push_back(p);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_product want;
        if (!i_rst_n) begin
            loaded_count = 0;
            product_queue.delete();
        end else begin
            // result side first: a result never belongs to a request of the same edge
            if (i_prod_valid && !i_prod_stall) begin
                if (product_queue.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected product %0d last %0b",
                                 i_product_element, i_is_last);
                    mismatch_count++;
                end else begin
                    want = product_queue.pop_front();
                    if (i_product_element !== want.value || i_is_last !== want.last) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("product mismatch: got %0d last %0b, expected %0d last %0b",
                                     i_product_element, i_is_last, want.value, want.last);
                        mismatch_count++;
                    end
                end
            end
            // load a then b; the last b element releases the products
            if (i_elem_valid && !i_elem_stall) begin
                if (loaded_count < CELLS)
                    matrix_a[loaded_count] = t_elem'(i_element);
                else
                    matrix_b[loaded_count - CELLS] = t_elem'(i_element);
                loaded_count++;
                if (loaded_count == 2 * CELLS) begin
                    push_products();
                    loaded_count = 0;
                end
            end
        end
        o_outstanding <= product_queue.size();
    end

endmodule

// File: tb/sv/testbench.sv
// drives matrix pairs into the multiplier with random gaps and result stalls
module testbench;
    import smm_pkg::*;

    localparam int CELLS        = DIM * DIM;
    localparam int RANDOM_PAIRS = 11;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 4 * DIM + 8;
    localparam int IDLE_LIMIT   = 2000;

    localparam t_elem ELEM_MIN = {1'b1, {(ELEMENT_WIDTH - 1){1'b0}}};
    localparam t_elem ELEM_MAX = {1'b0, {(ELEMENT_WIDTH - 1){1'b1}}};

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        i_valid   = 1'b0;
    logic                        o_stall;
    logic signed [IN_WIDTH-1:0]  i_element = '0;
    logic                        o_valid;
    logic                        i_stall   = 1'b0;
    logic signed [SUM_WIDTH-1:0] o_product_element;
    logic                        o_is_last;

    int mismatch_count;
    int outstanding;
    int idle_cycles;

    square_matrix_multiply_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_element         (i_element),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_product_element (o_product_element),
        .o_is_last         (o_is_last)
    );

    matrix_product_checker product_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_elem_valid      (i_valid),
        .i_elem_stall      (o_stall),
        .i_element         (i_element),
        .i_prod_valid      (o_valid),
        .i_prod_stall      (i_stall),
        .i_product_element (o_product_element),
        .i_is_last         (o_is_last),
        .o_mismatch_count  (mismatch_count),
        .o_outstanding     (outstanding)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one request, after an optional gap; returns at the accepting edge
    task automatic send_element(input t_elem value, input bit eager);
        int gap;
        gap = eager ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // mix of extremes, small values and full-range values
    function automatic t_elem random_element();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
            1: return t_elem'($urandom_range(0, 8) - 4);
            default: return t_elem'($urandom_range(0, 65535));
        endcase
    endfunction

    // result side: a random stall before each result, with quiet stretches
    initial begin
        int  wait_cycles;
        int  taken;
        bit  quiet;
        taken = 0;
        quiet = 1'b0;
        forever begin
            if (taken % CELLS == 0)
                quiet = ($urandom_range(0, 3) == 0);
            wait_cycles = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    // watchdog on cycles with no accepted request or result
    initial begin
        idle_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end while (idle_cycles < IDLE_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // stimulus and verdict
    initial begin
        bit eager;
        int tail;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pair: rows of min, max and small values against columns of
        // min, max and zero, hitting both ends of the product range
        for (int row = 0; row < DIM; row++)
            for (int k = 0; k < DIM; k++)
                send_element(row == 0 ? ELEM_MIN : row == 1 ? ELEM_MAX : t_elem'(1 - k), 1'b0);
        for (int k = 0; k < DIM; k++)
            for (int col = 0; col < DIM; col++)
                send_element(col == 0 ? ELEM_MIN : col == 1 ? ELEM_MAX : t_elem'(0), 1'b0);

        // random pairs, some sent back to back
        for (int pair = 0; pair < RANDOM_PAIRS; pair++) begin
            eager = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 2 * CELLS; n++)
                send_element(random_element(), eager);
        end

        // trailing partial pair must produce nothing
        tail = $urandom_range(0, 2 * CELLS - 1);
        for (int n = 0; n < tail; n++)
            send_element(random_element(), 1'b0);
        i_valid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: square_matrix_multiply_core.f
rtl/smm_pkg.sv
rtl/smm_cell.sv
rtl/square_matrix_multiply_core.sv
tb/sv/matrix_product_checker.sv
tb/sv/testbench.sv
